// ===== design/tmei_pkg.sv =====
// Shared types, opcode selector constants and immediate encoding functions.
package tmei_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned PosW  = 5;

  localparam logic [WordW-1:0] SEL_MASK    = 32'h01f0_0000;
  localparam logic [WordW-1:0] SEL_ADD     = 32'h0100_0000;
  localparam logic [WordW-1:0] SEL_SUB     = 32'h01a0_0000;
  localparam logic [WordW-1:0] SEL_ORR_MOV = 32'h0040_0000;
  localparam logic [WordW-1:0] SEL_ORN_MVN = 32'h0060_0000;
  localparam logic [WordW-1:0] SEL_AND     = 32'h0000_0000;
  localparam logic [WordW-1:0] SEL_BIC     = 32'h0020_0000;
  localparam logic [WordW-1:0] RN_FIELD    = 32'h000f_0000;
  localparam logic [WordW-1:0] FLIP_ADDSUB = 32'h00a0_0000;
  localparam logic [WordW-1:0] FLIP_LOGIC  = 32'h0020_0000;

  localparam logic [3:0] PAT_LO  = 4'h1;
  localparam logic [3:0] PAT_HI  = 4'h2;
  localparam logic [3:0] PAT_ALL = 4'h3;

  typedef struct packed {
    logic [WordW-1:0] tmpl;
    logic [WordW-1:0] val;
    logic [WordW-1:0] alt_tmpl;
    logic [WordW-1:0] alt_val;
    logic             has_alt;
  } prep_t;

  typedef struct packed {
    logic [WordW-1:0] val;
    logic             is_byte;
    logic             pat_lo;
    logic             pat_hi;
    logic             pat_all;
    logic [PosW-1:0]  msb;
    logic [PosW-1:0]  lsb;
  } scan_t;

  typedef struct packed {
    logic [WordW-1:0] tmpl;
    logic [WordW-1:0] alt_tmpl;
    logic             has_alt;
    scan_t            dir;
    scan_t            alt;
  } scanned_t;

  typedef struct packed {
    logic             ok;
    logic [WordW-1:0] bits;
  } imm_t;

  typedef struct packed {
    logic [WordW-1:0] word;
    logic             fits;
    logic             used_alt;
  } result_t;

  // Pattern compares plus the highest and lowest set bit positions.
  function automatic scan_t scan_value(logic [WordW-1:0] v);
    scan_t s;
    s.val     = v;
    s.is_byte = (v[WordW-1:8] == '0);
    s.pat_lo  = (v == {8'h00, v[7:0], 8'h00, v[7:0]});
    s.pat_hi  = (v == {v[15:8], 8'h00, v[15:8], 8'h00});
    s.pat_all = (v == {4{v[7:0]}});
    s.msb     = '0;
    s.lsb     = '0;
    for (int i = 0; i < WordW; i++) begin
      if (v[i]) s.msb = PosW'(i);
    end
    for (int i = WordW - 1; i >= 0; i--) begin
      if (v[i]) s.lsb = PosW'(i);
    end
    return s;
  endfunction

  // Build i:imm3:a:imm8 from a scanned value; the rotated form needs all set
  // bits inside one byte whose top bit is the leading one.
  function automatic imm_t imm_fields(scan_t s);
    imm_t            r;
    logic [PosW-1:0] sh;
    logic [PosW-1:0] rot;
    logic [PosW-1:0] span;
    logic [WordW-1:0] shifted;
    sh      = s.msb - PosW'(7);
    rot     = PosW'(6'd39 - {1'b0, s.msb});
    span    = s.msb - s.lsb;
    shifted = s.val >> sh;
    r.ok    = 1'b1;
    priority if (s.is_byte) begin
      r.bits = s.val;
    end else if (s.pat_lo) begin
      r.bits = {16'h0, PAT_LO, 4'h0, s.val[7:0]};
    end else if (s.pat_hi) begin
      r.bits = {16'h0, PAT_HI, 4'h0, s.val[15:8]};
    end else if (s.pat_all) begin
      r.bits = {16'h0, PAT_ALL, 4'h0, s.val[7:0]};
    end else if (span <= PosW'(7)) begin
      r.bits = {5'h0, rot[4], 11'h0, rot[3:1], 4'h0, rot[0], shifted[6:0]};
    end else begin
      r.ok   = 1'b0;
      r.bits = '0;
    end
    return r;
  endfunction

endpackage

// ===== design/thumb2_modified_immediate_encoder.sv =====
// Top level of the Thumb-2 modified immediate encoder pipeline.
//
// Input stream: one item per handshake carries an instruction template and a
// 32-bit constant. The block tries the constant as a plain byte, one of the
// three replicated-byte patterns or a rotated 8-bit value; failing that, it
// retries with the partner opcode (ADD/SUB with the negated constant,
// MOV/MVN and AND/BIC with the inverted constant).
// Output stream: one item per input item, in order: the encoded word in tdata
// (zero when nothing fits) and the fits / alternate flags in tuser.
// Pipeline: one register per stage (decode and negate, pattern and span scan,
// field build and select).
// Throughput: one item per cycle while the output is taken; every stage has its
// own valid bit and refills while a later stage is stalled.
// Stall: when the output is not taken, the item holds in the output stage and
// the stages behind it fill up; s_axis_tready drops only when all three hold
// an item. Nothing is dropped or repeated.
// Reset: all valid bits clear; the pipeline is empty and ready at once.
module thumb2_modified_immediate_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] op_word, [63:32] constant
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] encoded_word
  output logic [1:0]  m_axis_tuser    // [0] fits, [1] used_alternate
);
  import tmei_pkg::*;

  logic     prep_valid, prep_ready;
  logic     scan_valid, scan_ready;
  prep_t    prep_data;
  scanned_t scan_data;
  result_t  res_data;

  tmei_prep u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s_axis_tvalid),
    .ready_o    (s_axis_tready),
    .op_word_i  (s_axis_tdata[31:0]),
    .constant_i (s_axis_tdata[63:32]),
    .valid_o    (prep_valid),
    .ready_i    (prep_ready),
    .data_o     (prep_data)
  );

  tmei_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prep_valid),
    .ready_o (prep_ready),
    .data_i  (prep_data),
    .valid_o (scan_valid),
    .ready_i (scan_ready),
    .data_o  (scan_data)
  );

  tmei_pack u_pack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (scan_valid),
    .ready_o (scan_ready),
    .data_i  (scan_data),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (res_data)
  );

  assign m_axis_tdata = res_data.word;
  assign m_axis_tuser = {res_data.used_alt, res_data.fits};

`ifndef SYNTH
  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (prep_valid && scan_valid && m_axis_tvalid))
    else $error("input stalled with a bubble in the pipeline");

  a_drain_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (scan_valid && !m_axis_tvalid) |=> m_axis_tvalid)
    else $error("scanned item did not move to output");

  a_ready_on_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input blocked while output drains");
`endif

endmodule

// ===== design/tmei_prep.sv =====
// Stage 1: decode the opcode selector and form the alternate template and constant.
module tmei_prep (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic [tmei_pkg::WordW-1:0] op_word_i,
  input  logic [tmei_pkg::WordW-1:0] constant_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output tmei_pkg::prep_t            data_o
);
  import tmei_pkg::*;

  logic  valid_q;
  prep_t data_d, data_q;

  always_comb begin
    data_d          = '0;
    data_d.tmpl     = op_word_i;
    data_d.val      = constant_i;
    data_d.has_alt  = 1'b0;
    data_d.alt_tmpl = '0;
    data_d.alt_val  = '0;
    unique case (op_word_i & SEL_MASK)
      SEL_ADD, SEL_SUB: begin
        data_d.has_alt  = 1'b1;
        data_d.alt_tmpl = op_word_i ^ FLIP_ADDSUB;
        data_d.alt_val  = -constant_i;
      end
      SEL_ORR_MOV, SEL_ORN_MVN: begin
        // only MOV and MVN (Rn all ones) have a partner
        if ((op_word_i & RN_FIELD) == RN_FIELD) begin
          data_d.has_alt  = 1'b1;
          data_d.alt_tmpl = op_word_i ^ FLIP_LOGIC;
          data_d.alt_val  = ~constant_i;
        end
      end
      SEL_AND, SEL_BIC: begin
        data_d.has_alt  = 1'b1;
        data_d.alt_tmpl = op_word_i ^ FLIP_LOGIC;
        data_d.alt_val  = ~constant_i;
      end
      default: begin
        data_d.has_alt = 1'b0;
      end
    endcase
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== design/tmei_scan.sv =====
// Stage 2: pattern compares and set-bit span search for both candidate constants.
module tmei_scan (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  tmei_pkg::prep_t    data_i,
  output logic               valid_o,
  input  logic               ready_i,
  output tmei_pkg::scanned_t data_o
);
  import tmei_pkg::*;

  logic     valid_q;
  scanned_t data_d, data_q;

  always_comb begin
    data_d.tmpl     = data_i.tmpl;
    data_d.alt_tmpl = data_i.alt_tmpl;
    data_d.has_alt  = data_i.has_alt;
    data_d.dir      = scan_value(data_i.val);
    data_d.alt      = scan_value(data_i.alt_val);
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== design/tmei_pack.sv =====
// Stage 3: build immediate fields, pick direct or alternate, hold the output item.
module tmei_pack (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  tmei_pkg::scanned_t data_i,
  output logic               valid_o,
  input  logic               ready_i,
  output tmei_pkg::result_t  data_o
);
  import tmei_pkg::*;

  logic    valid_q;
  imm_t    dir_imm, alt_imm;
  result_t data_d, data_q;

  always_comb begin
    dir_imm = imm_fields(data_i.dir);
    alt_imm = imm_fields(data_i.alt);
    priority if (dir_imm.ok) begin
      data_d.word     = data_i.tmpl | dir_imm.bits;
      data_d.fits     = 1'b1;
      data_d.used_alt = 1'b0;
    end else if (data_i.has_alt && alt_imm.ok) begin
      data_d.word     = data_i.alt_tmpl | alt_imm.bits;
      data_d.fits     = 1'b1;
      data_d.used_alt = 1'b1;
    end else begin
      data_d.word     = '0;
      data_d.fits     = 1'b0;
      data_d.used_alt = 1'b0;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

`ifndef SYNTH
  a_alt_needs_fit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (!data_q.used_alt || data_q.fits))
    else $error("alternate flagged without a fit");

  a_nofit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !data_q.fits) |-> (data_q.word == '0))
    else $error("word not cleared on a miss");

  a_load_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ready_o && valid_i) |=> valid_q)
    else $error("accepted item lost in output stage");
`endif

endmodule
